// ----- rtl/checksummed_frame_parser_assert.svh -----
// assertion macros for the frame parser
// no dependencies; the including module must have clock and reset in scope
`ifndef CHECKSUMMED_FRAME_PARSER_ASSERT_SVH
`define CHECKSUMMED_FRAME_PARSER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cfp_pkg.sv -----
// types and constants shared by the frame parser modules
// no dependencies
`timescale 1ns / 1ps

package cfp_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int POS_WIDTH = 9;
   localparam int MIN_FRAME = 6;

   localparam logic [POS_WIDTH-1:0] POS_HEADER = POS_WIDTH'(0);
   localparam logic [POS_WIDTH-1:0] POS_ADDRESS = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_COMMAND = POS_WIDTH'(2);
   localparam logic [POS_WIDTH-1:0] POS_LENGTH = POS_WIDTH'(3);
   localparam logic [POS_WIDTH-1:0] POS_PAYLOAD = POS_WIDTH'(4);
   localparam logic [POS_WIDTH-1:0] POS_MIN_LAST = POS_WIDTH'(MIN_FRAME - 1);
   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

   localparam logic [BYTE_WIDTH-1:0] HEADER_RESET = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] TAIL_RESET = 8'h55;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HEADER_MARKER = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TAIL_MARKER = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_TOO_SHORT   = 3'd1,
      STATUS_BAD_HEADER  = 3'd2,
      STATUS_BAD_TAIL    = 3'd3,
      STATUS_LENGTH      = 3'd4,
      STATUS_CHECKSUM    = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] header;
      logic [BYTE_WIDTH-1:0] tail;
   } markers_type;

   typedef struct packed {
      logic                  kind;
      logic [BYTE_WIDTH-1:0] payload_value;
      logic [BYTE_WIDTH-1:0] payload_index;
      status_type            status;
      logic [BYTE_WIDTH-1:0] address;
      logic [BYTE_WIDTH-1:0] command;
      logic [BYTE_WIDTH-1:0] length;
   } result_type;

endpackage

// ----- rtl/cfp_csr.sv -----
// marker registers of the frame parser, written through the csr port
// depends on cfp_pkg
`timescale 1ns / 1ps

module cfp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [cfp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cfp_pkg::BYTE_WIDTH-1:0]      csr_write_data,
   output cfp_pkg::markers_type                markers
);

   cfp_pkg::markers_type markers_ff;
   cfp_pkg::markers_type markers_in;

   always_comb begin
      markers_in = markers_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cfp_pkg::REG_HEADER_MARKER: markers_in.header = csr_write_data;
            cfp_pkg::REG_TAIL_MARKER:   markers_in.tail = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         markers_ff.header <= cfp_pkg::HEADER_RESET;
         markers_ff.tail <= cfp_pkg::TAIL_RESET;
      end else begin
         markers_ff <= markers_in;
      end
   end

   assign markers = markers_ff;

endmodule

// ----- rtl/cfp_frame.sv -----
// per-frame state and result logic: position, checksum, held fields, status checks
// depends on cfp_pkg and checksummed_frame_parser_assert.svh
`timescale 1ns / 1ps
`include "checksummed_frame_parser_assert.svh"

module cfp_frame (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [cfp_pkg::BYTE_WIDTH-1:0] rx_byte,
   input  logic                           frame_end,
   input  cfp_pkg::markers_type           markers,
   output logic                           has_result,
   output cfp_pkg::result_type            result
);

   logic [cfp_pkg::POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [cfp_pkg::BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic [cfp_pkg::BYTE_WIDTH-1:0] prev_ff, prev_in;
   logic                           hdr_ff, hdr_in;
   logic [cfp_pkg::BYTE_WIDTH-1:0] addr_ff, addr_in;
   logic [cfp_pkg::BYTE_WIDTH-1:0] cmd_ff, cmd_in;
   logic [cfp_pkg::BYTE_WIDTH-1:0] len_ff, len_in;

   logic                           hdr_now;
   logic [cfp_pkg::BYTE_WIDTH-1:0] addr_now, cmd_now, len_now;
   logic [cfp_pkg::POS_WIDTH-1:0]  payload_end;
   logic [cfp_pkg::POS_WIDTH-1:0]  expected_last;
   logic [cfp_pkg::POS_WIDTH-1:0]  index_full;
   logic                           in_payload;
   cfp_pkg::status_type            status;

   // fields as they stand once this byte is taken in
   always_comb begin
      hdr_now = hdr_ff;
      addr_now = addr_ff;
      cmd_now = cmd_ff;
      len_now = len_ff;
      unique case (pos_ff)
         cfp_pkg::POS_HEADER:  hdr_now = (rx_byte == markers.header);
         cfp_pkg::POS_ADDRESS: addr_now = rx_byte;
         cfp_pkg::POS_COMMAND: cmd_now = rx_byte;
         cfp_pkg::POS_LENGTH:  len_now = rx_byte;
         default: ;
      endcase
   end

   assign payload_end = {1'b0, len_ff} + cfp_pkg::POS_PAYLOAD;
   assign expected_last = {1'b0, len_now} + cfp_pkg::POS_MIN_LAST;
   assign index_full = pos_ff - cfp_pkg::POS_PAYLOAD;
   assign in_payload = (pos_ff >= cfp_pkg::POS_PAYLOAD) && (pos_ff < payload_end);

   always_comb begin
      if (pos_ff < cfp_pkg::POS_MIN_LAST) begin
         status = cfp_pkg::STATUS_TOO_SHORT;
      end else if (!hdr_now) begin
         status = cfp_pkg::STATUS_BAD_HEADER;
      end else if (rx_byte != markers.tail) begin
         status = cfp_pkg::STATUS_BAD_TAIL;
      end else if (pos_ff != expected_last) begin
         status = cfp_pkg::STATUS_LENGTH;
      end else if (sum_ff != prev_ff) begin
         status = cfp_pkg::STATUS_CHECKSUM;
      end else begin
         status = cfp_pkg::STATUS_OK;
      end
   end

   always_comb begin
      has_result = frame_end || in_payload;
      result.address = addr_now;
      result.command = cmd_now;
      result.length = len_now;
      if (frame_end) begin
         result.kind = cfp_pkg::KIND_STATUS;
         result.payload_value = '0;
         result.payload_index = '0;
         result.status = status;
      end else begin
         result.kind = cfp_pkg::KIND_PAYLOAD;
         result.payload_value = rx_byte;
         result.payload_index = index_full[cfp_pkg::BYTE_WIDTH-1:0];
         result.status = cfp_pkg::STATUS_OK;
      end
   end

   // next frame state
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      prev_in = prev_ff;
      hdr_in = hdr_ff;
      addr_in = addr_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      if (step) begin
         if (frame_end) begin
            pos_in = '0;
            sum_in = '0;
            prev_in = '0;
            hdr_in = 1'b0;
            addr_in = '0;
            cmd_in = '0;
            len_in = '0;
         end else begin
            if (pos_ff != cfp_pkg::POS_MAX) begin
               pos_in = pos_ff + cfp_pkg::POS_WIDTH'(1);
            end
            if (pos_ff != cfp_pkg::POS_HEADER) begin
               sum_in = sum_ff + prev_ff;
            end
            prev_in = rx_byte;
            hdr_in = hdr_now;
            addr_in = addr_now;
            cmd_in = cmd_now;
            len_in = len_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         prev_ff <= '0;
         hdr_ff <= 1'b0;
         addr_ff <= '0;
         cmd_ff <= '0;
         len_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         prev_ff <= prev_in;
         hdr_ff <= hdr_in;
         addr_ff <= addr_in;
         cmd_ff <= cmd_in;
         len_ff <= len_in;
      end
   end

   `CFP_ASSERT(a_end_gives_status, !(step && frame_end) || (has_result && result.kind == cfp_pkg::KIND_STATUS), "final byte without status result")
   `CFP_ASSERT_NEXT(a_end_clears_position, step && frame_end, pos_ff == cfp_pkg::POS_HEADER && sum_ff == '0, "frame state not cleared after final byte")
   `CFP_ASSERT_NEXT(a_position_advances, step && !frame_end && pos_ff != cfp_pkg::POS_MAX, pos_ff == $past(pos_ff) + cfp_pkg::POS_WIDTH'(1), "byte position did not advance")

endmodule

// ----- rtl/checksummed_frame_parser.sv -----
// One received byte is taken per clock cycle, with frame_end flagging the
// final byte of a frame. Each byte is held in an input register, runs through
// one 8-bit add and a few compares, and any result lands in an output register
// as the held byte leaves the input register; a payload byte gives a payload
// transaction, the final byte gives one status transaction. Sustained rate is
// one byte per cycle while rsp_stall is low; a stalled result holds the output
// register and backs up the input register, after which req_stall rises.
// Payload bytes come out before the frame's status is known.
// depends on cfp_pkg, cfp_csr and cfp_frame
`timescale 1ns / 1ps

module checksummed_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cfp_pkg::BYTE_WIDTH-1:0]      req_rx_byte,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_payload_value,
   output logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_payload_index,
   output logic [2:0]                          rsp_frame_status,
   output logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_frame_address,
   output logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_frame_command,
   output logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_payload_length,
   input  logic                                csr_write_enable,
   input  logic [cfp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cfp_pkg::BYTE_WIDTH-1:0]      csr_write_data
);

   cfp_pkg::markers_type           markers;
   logic                           in_valid_ff, in_valid_in;
   logic [cfp_pkg::BYTE_WIDTH-1:0] in_byte_ff;
   logic                           in_end_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   cfp_pkg::result_type            rsp_result_ff;
   cfp_pkg::result_type            result;
   logic                           has_result;
   logic                           accept;
   logic                           advance;

   cfp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .markers          (markers)
   );

   cfp_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .frame_end  (in_end_ff),
      .markers    (markers),
      .has_result (has_result),
      .result     (result)
   );

   // held byte moves on unless its result finds the output register blocked
   assign advance = in_valid_ff && (!has_result || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
         in_end_ff <= req_frame_end;
      end
      if (advance && has_result) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_result_ff.kind;
   assign rsp_payload_value = rsp_result_ff.payload_value;
   assign rsp_payload_index = rsp_result_ff.payload_index;
   assign rsp_frame_status = rsp_result_ff.status;
   assign rsp_frame_address = rsp_result_ff.address;
   assign rsp_frame_command = rsp_result_ff.command;
   assign rsp_payload_length = rsp_result_ff.length;

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for checksummed_frame_parser: frames of bytes go in,
// payload and status transactions are predicted by a scoreboard class and checked
// depends on cfp_pkg and the checksummed_frame_parser rtl
`timescale 1ns / 1ps

module testbench;

   class frame_scoreboard;
      cfp_pkg::markers_type                markers;
      logic [cfp_pkg::POS_WIDTH-1:0]       frame_position;
      logic [cfp_pkg::BYTE_WIDTH-1:0]      checksum_acc;
      logic [cfp_pkg::BYTE_WIDTH-1:0]      last_byte;
      logic                                header_seen;
      logic [cfp_pkg::BYTE_WIDTH-1:0]      frame_address;
      logic [cfp_pkg::BYTE_WIDTH-1:0]      frame_command;
      logic [cfp_pkg::BYTE_WIDTH-1:0]      frame_length;
      cfp_pkg::result_type                 expected_results[$];
      int                                  failures;

      function new();
         markers.header = cfp_pkg::HEADER_RESET;
         markers.tail = cfp_pkg::TAIL_RESET;
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_position = '0;
         checksum_acc = '0;
         last_byte = '0;
         header_seen = 1'b0;
         frame_address = '0;
         frame_command = '0;
         frame_length = '0;
      endfunction

      function void set_marker(logic [cfp_pkg::CSR_INDEX_WIDTH-1:0] index,
                               logic [cfp_pkg::BYTE_WIDTH-1:0] value);
         if (index == cfp_pkg::REG_HEADER_MARKER) markers.header = value;
         else markers.tail = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_rx_byte(logic [cfp_pkg::BYTE_WIDTH-1:0] rx, logic last);
         cfp_pkg::result_type r;
         logic [cfp_pkg::POS_WIDTH-1:0] pos;
         int size;
         pos = frame_position;
         if (pos == cfp_pkg::POS_HEADER) begin
            clear_frame();
            header_seen = (rx == markers.header);
         end else if (pos == cfp_pkg::POS_ADDRESS) begin
            frame_address = rx;
         end else if (pos == cfp_pkg::POS_COMMAND) begin
            frame_command = rx;
         end else if (pos == cfp_pkg::POS_LENGTH) begin
            frame_length = rx;
         end
         r.payload_value = '0;
         r.payload_index = '0;
         r.status = cfp_pkg::STATUS_OK;
         r.address = frame_address;
         r.command = frame_command;
         r.length = frame_length;
         if (last) begin
            size = int'(pos) + 1;
            r.kind = cfp_pkg::KIND_STATUS;
            if (size < cfp_pkg::MIN_FRAME) r.status = cfp_pkg::STATUS_TOO_SHORT;
            else if (!header_seen) r.status = cfp_pkg::STATUS_BAD_HEADER;
            else if (rx != markers.tail) r.status = cfp_pkg::STATUS_BAD_TAIL;
            else if (size != cfp_pkg::MIN_FRAME + int'(frame_length))
               r.status = cfp_pkg::STATUS_LENGTH;
            else if (checksum_acc != last_byte) r.status = cfp_pkg::STATUS_CHECKSUM;
            expected_results.push_back(r);
            clear_frame();
         end else begin
            if (pos >= cfp_pkg::POS_PAYLOAD && int'(pos) <= 3 + int'(frame_length)) begin
               r.kind = cfp_pkg::KIND_PAYLOAD;
               r.payload_value = rx;
               r.payload_index = cfp_pkg::BYTE_WIDTH'(pos - cfp_pkg::POS_PAYLOAD);
               expected_results.push_back(r);
            end
            if (pos != cfp_pkg::POS_HEADER) checksum_acc = checksum_acc + last_byte;
            last_byte = rx;
            if (pos != cfp_pkg::POS_MAX) frame_position = pos + 1'b1;
         end
      endfunction

      function void compare_field(string field, logic [cfp_pkg::BYTE_WIDTH-1:0] want,
                                  logic [cfp_pkg::BYTE_WIDTH-1:0] got);
         if (got !== want) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_result(cfp_pkg::result_type got);
         cfp_pkg::result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t unexpected transaction: kind %0h status %0h value %0h",
                     $time, got.kind, got.status, got.payload_value);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("result_kind", cfp_pkg::BYTE_WIDTH'(want.kind),
                       cfp_pkg::BYTE_WIDTH'(got.kind));
         compare_field("payload_value", want.payload_value, got.payload_value);
         compare_field("payload_index", want.payload_index, got.payload_index);
         compare_field("frame_status", cfp_pkg::BYTE_WIDTH'(want.status),
                       cfp_pkg::BYTE_WIDTH'(got.status));
         compare_field("frame_address", want.address, got.address);
         compare_field("frame_command", want.command, got.command);
         compare_field("payload_length", want.length, got.length);
      endfunction
   endclass

   typedef enum int {NO_STALL, LIGHT_STALL, HEAVY_STALL, BLOCKING_STALL} stall_pattern_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      req_rx_byte;
   logic                                req_frame_end;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic                                rsp_result_kind;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_payload_value;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_payload_index;
   logic [2:0]                          rsp_frame_status;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_frame_address;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_frame_command;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      rsp_payload_length;
   logic                                csr_write_enable;
   logic [cfp_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      csr_write_data;

   frame_scoreboard                     sb;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      frame_bytes[$];
   logic [cfp_pkg::BYTE_WIDTH-1:0]      header_now;
   logic [cfp_pkg::BYTE_WIDTH-1:0]      tail_now;
   int                                  items_sent;
   int                                  burst_left;
   stall_pattern_type                   stall_pattern;
   int                                  pattern_left;

   checksummed_frame_parser uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_payload_value(rsp_payload_value),
      .rsp_payload_index(rsp_payload_index),
      .rsp_frame_status(rsp_frame_status),
      .rsp_frame_address(rsp_frame_address),
      .rsp_frame_command(rsp_frame_command),
      .rsp_payload_length(rsp_payload_length),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // result side: check accepted transactions and stall on a changing pattern
   always @(posedge clock) begin : rsp_side
      cfp_pkg::result_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
         pattern_left <= 0;
         stall_pattern <= NO_STALL;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_result_kind;
            got.payload_value = rsp_payload_value;
            got.payload_index = rsp_payload_index;
            got.status = cfp_pkg::status_type'(rsp_frame_status);
            got.address = rsp_frame_address;
            got.command = rsp_frame_command;
            got.length = rsp_payload_length;
            sb.check_result(got);
         end
         if (pattern_left == 0) begin
            stall_pattern <= stall_pattern_type'($urandom_range(0, 3));
            pattern_left <= int'($urandom_range(10, 80));
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_pattern)
            NO_STALL: rsp_stall <= 1'b0;
            LIGHT_STALL: rsp_stall <= ($urandom_range(0, 3) == 0);
            HEAVY_STALL: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic send_byte(input logic [cfp_pkg::BYTE_WIDTH-1:0] rx, input logic last);
      int gap;
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      req_frame_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_rx_byte(rx, last);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 24));
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic fix_checksum();
      logic [cfp_pkg::BYTE_WIDTH-1:0] acc;
      acc = '0;
      for (int i = 0; i < frame_bytes.size() - 2; i++) acc = acc + frame_bytes[i];
      frame_bytes[frame_bytes.size() - 2] = acc;
   endtask

   function automatic logic [cfp_pkg::BYTE_WIDTH-1:0] random_byte();
      return cfp_pkg::BYTE_WIDTH'($urandom_range(0, 255));
   endfunction

   task automatic build_frame(input logic [cfp_pkg::BYTE_WIDTH-1:0] address,
                              input logic [cfp_pkg::BYTE_WIDTH-1:0] command, input int len);
      frame_bytes.delete();
      frame_bytes.push_back(header_now);
      frame_bytes.push_back(address);
      frame_bytes.push_back(command);
      frame_bytes.push_back(cfp_pkg::BYTE_WIDTH'(len));
      repeat (len) frame_bytes.push_back(random_byte());
      frame_bytes.push_back('0);
      frame_bytes.push_back(tail_now);
      fix_checksum();
   endtask

   // mostly well-formed frames, the rest broken in one way or plain noise
   task automatic random_frame();
      int roll;
      int len;
      int n;
      roll = int'($urandom_range(0, 99));
      len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40))
                                        : int'($urandom_range(0, 8));
      build_frame(random_byte(), random_byte(), len);
      if (roll < 55) begin
      end else if (roll < 63) begin
         frame_bytes[frame_bytes.size() - 2] ^= cfp_pkg::BYTE_WIDTH'($urandom_range(1, 255));
      end else if (roll < 70) begin
         frame_bytes[frame_bytes.size() - 1] ^= cfp_pkg::BYTE_WIDTH'($urandom_range(1, 255));
      end else if (roll < 77) begin
         frame_bytes[0] ^= cfp_pkg::BYTE_WIDTH'($urandom_range(1, 255));
      end else if (roll < 85) begin
         if (len > 0 && $urandom_range(0, 1) == 1) frame_bytes.delete(4);
         else frame_bytes.insert(4, random_byte());
         fix_checksum();
      end else if (roll < 92) begin
         n = int'($urandom_range(1, 5));
         while (frame_bytes.size() > n) frame_bytes.delete(frame_bytes.size() - 1);
      end else begin
         n = int'($urandom_range(1, 24));
         frame_bytes.delete();
         repeat (n) frame_bytes.push_back(random_byte());
      end
      send_frame();
   endtask

   task automatic run_random(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) random_frame();
   endtask

   task automatic write_marker(input logic [cfp_pkg::CSR_INDEX_WIDTH-1:0] index,
                               input logic [cfp_pkg::BYTE_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_marker(index, value);
      if (index == cfp_pkg::REG_HEADER_MARKER) header_now = value;
      else tail_now = value;
      @(posedge clock);
   endtask

   // drain outstanding results, then allow the pipeline to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      sb = new();
      header_now = cfp_pkg::HEADER_RESET;
      tail_now = cfp_pkg::TAIL_RESET;
      items_sent = 0;
      burst_left = 8;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      req_frame_end <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= cfp_pkg::REG_HEADER_MARKER;
      csr_write_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed frames with the reset markers
      frame_bytes = '{8'h00};
      send_frame();
      build_frame(8'hFF, 8'h00, 1);
      frame_bytes[4] = 8'hFF;
      fix_checksum();
      send_frame();
      build_frame(8'h00, 8'hFF, 0);
      frame_bytes[0] = ~header_now;
      send_frame();
      build_frame(8'h5A, 8'hA5, 0);
      frame_bytes[5] = ~tail_now;
      send_frame();
      // final byte lands inside the payload range
      build_frame(8'h01, 8'h80, 5);
      repeat (5) frame_bytes.delete(5);
      send_frame();
      run_random(55);
      settle();

      write_marker(cfp_pkg::REG_HEADER_MARKER, 8'h00);
      write_marker(cfp_pkg::REG_TAIL_MARKER, 8'hFF);
      build_frame(8'hC3, 8'h3C, 3);
      send_frame();
      run_random(55);
      settle();

      write_marker(cfp_pkg::REG_HEADER_MARKER, 8'hFF);
      write_marker(cfp_pkg::REG_TAIL_MARKER, 8'h00);
      // oversized frame with the largest length runs the position counter into saturation
      frame_bytes.delete();
      frame_bytes.push_back(header_now);
      repeat (540) frame_bytes.push_back(random_byte());
      frame_bytes[3] = 8'hFF;
      frame_bytes.push_back(tail_now);
      send_frame();
      run_random(55);
      settle();

      write_marker(cfp_pkg::REG_HEADER_MARKER, random_byte());
      write_marker(cfp_pkg::REG_TAIL_MARKER, random_byte());
      run_random(55);
      settle();

      write_marker(cfp_pkg::REG_HEADER_MARKER, 8'h5A);
      write_marker(cfp_pkg::REG_TAIL_MARKER, 8'h5A);
      run_random(55);
      settle();

      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
